@@ hdl/pfsa_pkg.sv @@
// Shared constants for the paced FIFO send arbiter: sizes, field widths,
// opcode, status and failure cause codes. No dependencies.
package pfsa_pkg;

  localparam int unsigned MEMBERS  = 16;
  localparam int unsigned MemberW  = $clog2(MEMBERS);
  localparam int unsigned PtrW     = MemberW + 1;
  localparam int unsigned CountW   = 5;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned BytesW   = 32;
  localparam int unsigned RateW    = 40;
  localparam int unsigned TotalW   = 64;
  localparam int unsigned DivCntW  = 6;

  localparam logic [PtrW-1:0]   NIL       = PtrW'(MEMBERS);
  localparam logic [RateW-1:0]  RATE_RST  = RateW'(125000000);
  localparam logic [TimeW-1:0]  NS_PER_S  = TimeW'(1000000000);

  localparam int unsigned InW  = 168;
  localparam int unsigned OutW = 216;

  typedef enum logic [2:0] {
    OP_ACQUIRE  = 3'd0,
    OP_COMPLETE = 3'd1,
    OP_ABANDON  = 3'd2,
    OP_LEAVE    = 3'd3,
    OP_POISON   = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WAIT     = 3'd1,
    ST_WAIT_T   = 3'd2,
    ST_FAILED   = 3'd3,
    ST_INVALID  = 3'd4,
    ST_MISS     = 3'd5,
    ST_MISMATCH = 3'd6,
    ST_OVERFLOW = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CS_NONE      = 3'd0,
    CS_ABANDONED = 3'd1,
    CS_MISMATCH  = 3'd2,
    CS_CNT_OVF   = 3'd3,
    CS_TIME_OVF  = 3'd4,
    CS_POISONED  = 3'd5
  } cause_e;

endpackage

@@ hdl/paced_fifo_send_arbiter_top.sv @@
// Paced FIFO send arbiter: FIFO member queue, single send permit, GCRA pacing.
// Depends on pfsa_pkg.
//
// Usage:
//   s_axis carries one command beat (acquire, complete, abandon, leave, poison).
//   m_axis returns exactly one result beat per command.
//   cfg_we_i/cfg_wdata_i write the rate register (bytes per second); write
//   only while no command is in flight.
// Command flow:
//   One command at a time; s_axis_tready is high only in the idle cycle.
//   Other commands pass decode, any states of their own and the output state.
//   A paced complete runs through decode, one multiply by 1e9, one add, a
//   bit-serial restoring divider against the rate register, one add and
//   one output state.
// Reset:
//   Queue empty, no permit, no pace time, counters zero, rate 125000000.
// Stall:
//   The result beat is held in the output register until m_axis_tready; the
//   next command is accepted meanwhile but its result waits for the slot.
module paced_fifo_send_arbiter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pfsa_pkg::RateW-1:0]   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // opcode[2:0], member_id[6:3], time_ns[69:7], wire_bytes[101:70],
  // deadline_ns[164:102], submission_started[165], zero[167:166]
  input  logic [pfsa_pkg::InW-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status[2:0], retry_time_ns[65:3], wake_valid[66], wake_member[70:67],
  // wake_all[71], waiting_count[76:72], charged_bytes[140:77],
  // charged_datagrams[204:141], failed[205], failure_cause[208:206], zero[215:209]
  output logic [pfsa_pkg::OutW-1:0]    m_axis_tdata
);

  localparam int unsigned MW = pfsa_pkg::MemberW;
  localparam int unsigned PW = pfsa_pkg::PtrW;
  localparam int unsigned TW = pfsa_pkg::TimeW;
  localparam int unsigned BW = pfsa_pkg::BytesW;
  localparam int unsigned RW = pfsa_pkg::RateW;
  localparam int unsigned CW = pfsa_pkg::TotalW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_APP0, S_APP1, S_ACQ_EVAL, S_UNLINK,
    S_MUL, S_ADDR, S_DIV, S_ADDT, S_RESP
  } state_e;

  state_e state_q;

  logic [2:0]    op_q;
  logic [MW-1:0] mem_q;
  logic [TW-1:0] time_q;
  logic [BW-1:0] bytes_q;
  logic [TW-1:0] dl_q;
  logic          started_q;

  logic [RW-1:0] rate_q;

  logic [PW-1:0] next_q [pfsa_pkg::MEMBERS];
  logic [PW-1:0] prev_q [pfsa_pkg::MEMBERS];
  logic [pfsa_pkg::MEMBERS-1:0] flag_q;
  logic [PW-1:0] head_q, tail_q, old_tail_q;
  logic [pfsa_pkg::CountW-1:0] count_q;

  logic          active_q;
  logic [MW-1:0] active_mem_q;
  logic [BW-1:0] permit_bytes_q;
  logic [TW-1:0] permit_start_q;
  logic          pace_valid_q;
  logic [TW-1:0] pace_q;
  logic          fail_q;
  logic [2:0]    cause_q;
  logic [CW-1:0] btotal_q, dtotal_q;

  logic [TW-1:0] num_q;
  logic [RW-1:0] rem_q;
  logic [pfsa_pkg::DivCntW-1:0] cnt_q;

  logic [2:0]    status_q;
  logic [TW-1:0] retry_q;
  logic          notify_q;

  logic                 out_valid_q;
  logic [pfsa_pkg::OutW-1:0] out_data_q;

  logic [RW:0]   trial, diff;
  logic          ge;
  logic [TW:0]   tsum;
  logic [PW-1:0] up, un;
  logic [PW-1:0] mem_ext;
  logic          invalid_acq;
  logic          wake_valid, wake_all;
  logic [MW-1:0] wake_mem;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign trial   = {rem_q, num_q[TW-1]};
  assign ge      = (trial >= {1'b0, rate_q});
  assign diff    = trial - {1'b0, rate_q};
  assign tsum    = {1'b0, time_q} + {1'b0, num_q};
  assign up      = prev_q[mem_q];
  assign un      = next_q[mem_q];
  assign mem_ext = {1'b0, mem_q};

  assign invalid_acq = (bytes_q == '0) || (time_q > dl_q) ||
                       !(mem_ext < pfsa_pkg::NIL) ||
                       (active_q && (active_mem_q == mem_q));

  assign wake_valid = notify_q && (head_q < pfsa_pkg::NIL);
  assign wake_all   = wake_valid && fail_q;
  assign wake_mem   = (wake_valid && !fail_q) ? head_q[MW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rate_q         <= pfsa_pkg::RATE_RST;
      for (int i = 0; i < pfsa_pkg::MEMBERS; i++) begin
        next_q[i] <= pfsa_pkg::NIL;
        prev_q[i] <= pfsa_pkg::NIL;
      end
      flag_q         <= '0;
      head_q         <= pfsa_pkg::NIL;
      tail_q         <= pfsa_pkg::NIL;
      old_tail_q     <= pfsa_pkg::NIL;
      count_q        <= '0;
      active_q       <= 1'b0;
      active_mem_q   <= '0;
      permit_bytes_q <= '0;
      permit_start_q <= '0;
      pace_valid_q   <= 1'b0;
      pace_q         <= '0;
      fail_q         <= 1'b0;
      cause_q        <= pfsa_pkg::CS_NONE;
      btotal_q       <= '0;
      dtotal_q       <= '0;
      out_valid_q    <= 1'b0;
      notify_q       <= 1'b0;
      status_q       <= pfsa_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q      <= s_axis_tdata[2:0];
            mem_q     <= s_axis_tdata[6:3];
            time_q    <= s_axis_tdata[69:7];
            bytes_q   <= s_axis_tdata[101:70];
            dl_q      <= s_axis_tdata[164:102];
            started_q <= s_axis_tdata[165];
            status_q  <= pfsa_pkg::ST_OK;
            retry_q   <= '0;
            notify_q  <= 1'b0;
            state_q   <= S_DECODE;
          end
        end

        S_DECODE: begin
          state_q <= S_RESP;
          unique case (op_q)
            pfsa_pkg::OP_ACQUIRE: begin
              if (fail_q) begin
                status_q <= pfsa_pkg::ST_FAILED;
              end else if (invalid_acq) begin
                status_q <= pfsa_pkg::ST_INVALID;
              end else if (flag_q[mem_q]) begin
                state_q <= S_ACQ_EVAL;
              end else begin
                state_q <= S_APP0;
              end
            end
            pfsa_pkg::OP_COMPLETE: begin
              if (!active_q) begin
                status_q <= pfsa_pkg::ST_INVALID;
              end else if (!started_q || (bytes_q > permit_bytes_q) ||
                           (time_q < permit_start_q)) begin
                status_q <= pfsa_pkg::ST_MISMATCH;
                if (!fail_q) begin
                  fail_q  <= 1'b1;
                  cause_q <= pfsa_pkg::CS_MISMATCH;
                end
                active_q <= 1'b0;
                notify_q <= 1'b1;
              end else if ((CW'(bytes_q) > ~btotal_q) ||
                           ((bytes_q != '0) && (dtotal_q == '1))) begin
                status_q <= pfsa_pkg::ST_OVERFLOW;
                if (!fail_q) begin
                  fail_q  <= 1'b1;
                  cause_q <= pfsa_pkg::CS_CNT_OVF;
                end
                active_q <= 1'b0;
                notify_q <= 1'b1;
              end else if (bytes_q != '0) begin
                btotal_q <= btotal_q + CW'(bytes_q);
                dtotal_q <= dtotal_q + CW'(1);
                if (rate_q == '0) begin
                  status_q <= pfsa_pkg::ST_OVERFLOW;
                  if (!fail_q) begin
                    fail_q  <= 1'b1;
                    cause_q <= pfsa_pkg::CS_TIME_OVF;
                  end
                  active_q <= 1'b0;
                  notify_q <= 1'b1;
                end else begin
                  state_q <= S_MUL;
                end
              end else begin
                active_q <= 1'b0;
                notify_q <= 1'b1;
              end
            end
            pfsa_pkg::OP_ABANDON: begin
              if (active_q) begin
                if (started_q && !fail_q) begin
                  fail_q  <= 1'b1;
                  cause_q <= pfsa_pkg::CS_ABANDONED;
                end
                active_q <= 1'b0;
                notify_q <= 1'b1;
              end
            end
            pfsa_pkg::OP_LEAVE: begin
              if (mem_ext < pfsa_pkg::NIL) begin
                notify_q <= 1'b1;
                state_q  <= S_UNLINK;
              end
            end
            pfsa_pkg::OP_POISON: begin
              if (active_q) begin
                if (!fail_q) begin
                  fail_q  <= 1'b1;
                  cause_q <= pfsa_pkg::CS_POISONED;
                end
                notify_q <= 1'b1;
              end
            end
            default: begin
              status_q <= pfsa_pkg::ST_INVALID;
            end
          endcase
        end

        S_APP0: begin
          prev_q[mem_q] <= tail_q;
          flag_q[mem_q] <= 1'b1;
          count_q       <= count_q + pfsa_pkg::CountW'(1);
          tail_q        <= mem_ext;
          old_tail_q    <= tail_q;
          if (tail_q < pfsa_pkg::NIL) begin
            state_q <= S_APP1;
          end else begin
            head_q  <= mem_ext;
            state_q <= S_ACQ_EVAL;
          end
        end

        S_APP1: begin
          next_q[old_tail_q[MW-1:0]] <= mem_ext;
          state_q <= S_ACQ_EVAL;
        end

        S_ACQ_EVAL: begin
          priority if (active_q || (head_q != mem_ext)) begin
            status_q <= pfsa_pkg::ST_WAIT;
            retry_q  <= dl_q;
            state_q  <= S_RESP;
          end else if (pace_valid_q && (time_q < pace_q)) begin
            if (pace_q > dl_q) begin
              status_q <= pfsa_pkg::ST_MISS;
              notify_q <= 1'b1;
              state_q  <= S_UNLINK;
            end else begin
              status_q <= pfsa_pkg::ST_WAIT_T;
              retry_q  <= pace_q;
              state_q  <= S_RESP;
            end
          end else begin
            active_q       <= 1'b1;
            active_mem_q   <= mem_q;
            permit_bytes_q <= bytes_q;
            permit_start_q <= time_q;
            state_q        <= S_UNLINK;
          end
        end

        S_UNLINK: begin
          if (flag_q[mem_q]) begin
            if (up < pfsa_pkg::NIL) begin
              next_q[up[MW-1:0]] <= un;
            end else begin
              head_q <= un;
            end
            if (un < pfsa_pkg::NIL) begin
              prev_q[un[MW-1:0]] <= up;
            end else begin
              tail_q <= up;
            end
            next_q[mem_q] <= pfsa_pkg::NIL;
            flag_q[mem_q] <= 1'b0;
            count_q       <= count_q - pfsa_pkg::CountW'(1);
          end
          state_q <= S_RESP;
        end

        S_MUL: begin
          num_q   <= TW'(bytes_q) * pfsa_pkg::NS_PER_S;
          state_q <= S_ADDR;
        end

        S_ADDR: begin
          num_q   <= num_q + TW'(rate_q - RW'(1));
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
          num_q <= {num_q[TW-2:0], ge};
          cnt_q <= cnt_q + pfsa_pkg::DivCntW'(1);
          if (cnt_q == pfsa_pkg::DivCntW'(TW - 1)) begin
            state_q <= S_ADDT;
          end
        end

        S_ADDT: begin
          if (tsum[TW]) begin
            status_q <= pfsa_pkg::ST_OVERFLOW;
            if (!fail_q) begin
              fail_q  <= 1'b1;
              cause_q <= pfsa_pkg::CS_TIME_OVF;
            end
          end else begin
            pace_q       <= tsum[TW-1:0];
            pace_valid_q <= 1'b1;
          end
          active_q <= 1'b0;
          notify_q <= 1'b1;
          state_q  <= S_RESP;
        end

        S_RESP: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'b0, cause_q, fail_q, dtotal_q, btotal_q, count_q,
                            wake_all, wake_mem, wake_valid, retry_q, status_q};
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_paced_fifo_send_arbiter_top.sv @@
// Self-checking testbench for paced_fifo_send_arbiter_top: directed table then
// constrained-by-hand random command beats, checked against a local predictor.
// Depends on pfsa_pkg and the DUT only.
module tb_paced_fifo_send_arbiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_RSVD_LO = 3'd5;
  localparam logic [2:0]  OP_RSVD_HI = 3'd7;
  localparam logic [62:0] T_MAX      = {63{1'b1}};
  localparam logic [39:0] RATE_MAX   = {40{1'b1}};
  localparam int          NO_TYPED   = -1;

  typedef struct {
    logic [2:0]  op;
    logic [3:0]  member;
    logic [62:0] t_ns;
    logic [31:0] bytes;
    logic [62:0] dl_ns;
    logic        started;
    int          typed;
  } cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [62:0] retry;
    logic        wake_v;
    logic [3:0]  wake_m;
    logic        wake_all;
    logic [4:0]  waiting;
    logic [63:0] chg_bytes;
    logic [63:0] chg_dgrams;
    logic        failed;
    logic [2:0]  cause;
  } res_t;

  logic                       clk_i, rst_ni;
  logic                       cfg_we_i;
  logic [pfsa_pkg::RateW-1:0] cfg_wdata_i;
  logic                       s_axis_tvalid, s_axis_tready;
  logic [pfsa_pkg::InW-1:0]   s_axis_tdata;
  logic                       m_axis_tvalid, m_axis_tready;
  logic [pfsa_pkg::OutW-1:0]  m_axis_tdata;

  paced_fifo_send_arbiter_top dut (.*);

  // predictor state
  logic [pfsa_pkg::PtrW-1:0]  nxt_q [pfsa_pkg::MEMBERS];
  logic [pfsa_pkg::PtrW-1:0]  prv_q [pfsa_pkg::MEMBERS];
  bit                         in_q [pfsa_pkg::MEMBERS];
  logic [pfsa_pkg::PtrW-1:0]  head_q, tail_q;
  logic [4:0]                 n_wait;
  bit                         permit_v;
  logic [3:0]                 permit_m;
  logic [31:0]                permit_b;
  logic [62:0]                permit_t;
  bit                         pace_v;
  logic [62:0]                pace_t;
  bit                         fail_l;
  logic [2:0]                 fail_c;
  logic [63:0]                tot_bytes, tot_dgrams;
  logic [pfsa_pkg::RateW-1:0] rate;

  res_t        result_q [$];
  int          typed_q [$];
  int          errors, n_beats, n_results, n_grants, n_paced;
  logic [62:0] now;
  bit          quiet, hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("paced_fifo_send_arbiter_top regression: fail");
    $finish;
  end

  function automatic void q_drop(logic [3:0] m);
    if (!in_q[m]) return;
    if (prv_q[m] != pfsa_pkg::NIL) nxt_q[prv_q[m][pfsa_pkg::MemberW-1:0]] = nxt_q[m];
    else head_q = nxt_q[m];
    if (nxt_q[m] != pfsa_pkg::NIL) prv_q[nxt_q[m][pfsa_pkg::MemberW-1:0]] = prv_q[m];
    else tail_q = prv_q[m];
    prv_q[m] = pfsa_pkg::NIL;
    nxt_q[m] = pfsa_pkg::NIL;
    in_q[m] = 1'b0;
    n_wait--;
  endfunction

  function automatic void q_add(logic [3:0] m);
    if (in_q[m]) return;
    prv_q[m] = tail_q;
    nxt_q[m] = pfsa_pkg::NIL;
    if (tail_q != pfsa_pkg::NIL) nxt_q[tail_q[pfsa_pkg::MemberW-1:0]] = {1'b0, m};
    else head_q = {1'b0, m};
    tail_q = {1'b0, m};
    in_q[m] = 1'b1;
    n_wait++;
  endfunction

  function automatic void set_fail(logic [2:0] c);
    if (!fail_l) begin
      fail_l = 1'b1;
      fail_c = c;
    end
  endfunction

  function automatic void wake(ref res_t r);
    if (head_q == pfsa_pkg::NIL) return;
    r.wake_v = 1'b1;
    if (fail_l) r.wake_all = 1'b1;
    else r.wake_m = head_q[pfsa_pkg::MemberW-1:0];
  endfunction

  function automatic res_t arbiter_step(cmd_t c);
    res_t r;
    logic [64:0] num, dur, nt;
    r = '{default: '0};
    case (c.op)
      pfsa_pkg::OP_ACQUIRE: begin
        if (fail_l) r.status = pfsa_pkg::ST_FAILED;
        else if (c.bytes == 0 || c.t_ns > c.dl_ns || (permit_v && permit_m == c.member))
          r.status = pfsa_pkg::ST_INVALID;
        else begin
          q_add(c.member);
          if (permit_v || head_q != {1'b0, c.member}) begin
            r.status = pfsa_pkg::ST_WAIT;
            r.retry = c.dl_ns;
          end else if (pace_v && c.t_ns < pace_t) begin
            if (pace_t > c.dl_ns) begin
              q_drop(c.member);
              wake(r);
              r.status = pfsa_pkg::ST_MISS;
            end else begin
              r.status = pfsa_pkg::ST_WAIT_T;
              r.retry = pace_t;
            end
          end else begin
            q_drop(c.member);
            permit_v = 1'b1;
            permit_m = c.member;
            permit_b = c.bytes;
            permit_t = c.t_ns;
            n_grants++;
          end
        end
      end
      pfsa_pkg::OP_COMPLETE: begin
        if (!permit_v) r.status = pfsa_pkg::ST_INVALID;
        else begin
          if (!c.started || c.bytes > permit_b || c.t_ns < permit_t) begin
            r.status = pfsa_pkg::ST_MISMATCH;
            set_fail(pfsa_pkg::CS_MISMATCH);
          end else if (65'(c.bytes) + 65'(tot_bytes) > 65'({64{1'b1}}) ||
                       (c.bytes != 0 && tot_dgrams == {64{1'b1}})) begin
            r.status = pfsa_pkg::ST_OVERFLOW;
            set_fail(pfsa_pkg::CS_CNT_OVF);
          end else if (c.bytes != 0) begin
            tot_bytes += 64'(c.bytes);
            tot_dgrams++;
            if (rate == 0) begin
              r.status = pfsa_pkg::ST_OVERFLOW;
              set_fail(pfsa_pkg::CS_TIME_OVF);
            end else begin
              num = 65'(c.bytes) * 65'(1000000000) + 65'(rate) - 65'd1;
              dur = num / 65'(rate);
              nt  = 65'(c.t_ns) + dur;
              if (nt > 65'(T_MAX)) begin
                r.status = pfsa_pkg::ST_OVERFLOW;
                set_fail(pfsa_pkg::CS_TIME_OVF);
              end else begin
                pace_t = nt[62:0];
                pace_v = 1'b1;
                n_paced++;
              end
            end
          end
          permit_v = 1'b0;
          wake(r);
        end
      end
      pfsa_pkg::OP_ABANDON: begin
        if (permit_v) begin
          if (c.started) set_fail(pfsa_pkg::CS_ABANDONED);
          permit_v = 1'b0;
          wake(r);
        end
      end
      pfsa_pkg::OP_LEAVE: begin
        q_drop(c.member);
        wake(r);
      end
      pfsa_pkg::OP_POISON: begin
        if (permit_v) begin
          set_fail(pfsa_pkg::CS_POISONED);
          wake(r);
        end
      end
      default: r.status = pfsa_pkg::ST_INVALID;
    endcase
    r.waiting    = n_wait;
    r.chg_bytes  = tot_bytes;
    r.chg_dgrams = tot_dgrams;
    r.failed     = fail_l;
    r.cause      = fail_c;
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] op, logic [3:0] m, logic [62:0] t, logic [31:0] b,
                              logic [62:0] dl, logic st, int ty);
    cmd_t c;
    c = '{op: op, member: m, t_ns: t, bytes: b, dl_ns: dl, started: st, typed: ty};
    return c;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // Mostly well-formed permit traffic around a moving clock, plus some noise.
  function automatic cmd_t gen_beat(bit big_ok);
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c = mk(pfsa_pkg::OP_ACQUIRE, 4'($urandom), now, 32'($urandom_range(1, 2000)), now, 1'b1,
           NO_TYPED);
    if (r < 4) begin
      c = mk(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 4'($urandom), rand63(), $urandom,
             rand63(), 1'($urandom), NO_TYPED);
    end else if (r < 8) begin
      c.bytes = 0;
      c.t_ns = rand63();
      c.dl_ns = rand63();
      c.started = 1'($urandom);
    end else if (r < 13) begin
      c.op = pfsa_pkg::OP_LEAVE;
    end else if (permit_v && r < 60) begin
      c.op = pfsa_pkg::OP_COMPLETE;
      c.bytes = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(0, permit_b));
      c.t_ns = now + 63'($urandom_range(0, 2000));
    end else if (permit_v && r < 67) begin
      c.op = pfsa_pkg::OP_ABANDON;
      c.started = 1'b0;
    end else begin
      if (big_ok && $urandom_range(0, 7) == 0) c.bytes = $urandom | 32'd1;
      if (pace_v && pace_t > now && $urandom_range(0, 1) == 1) c.t_ns = pace_t;
      else c.t_ns = now + 63'($urandom_range(0, 3000));
      if ($urandom_range(0, 3) == 0) c.dl_ns = c.t_ns + 63'($urandom) * 63'd1000;
      else c.dl_ns = c.t_ns + 63'($urandom_range(0, 40000));
    end
    if (c.op == pfsa_pkg::OP_ACQUIRE && c.bytes != 0 || c.op == pfsa_pkg::OP_COMPLETE)
      now = c.t_ns;
    return c;
  endfunction

  task automatic send_beat(cmd_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, c.started, c.dl_ns, c.bytes, c.t_ns, c.member, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    result_q.push_back(arbiter_step(c));
    typed_q.push_back(c.typed);
    n_beats++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [pfsa_pkg::RateW-1:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rate = v;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    cmd_t dir_q [$];
    cmd_t c;
    logic [pfsa_pkg::RateW-1:0] rates [4];
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    rst_ni = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    for (int i = 0; i < pfsa_pkg::MEMBERS; i++) begin
      nxt_q[i] = pfsa_pkg::NIL;
      prv_q[i] = pfsa_pkg::NIL;
      in_q[i] = 1'b0;
    end
    head_q = pfsa_pkg::NIL;
    tail_q = pfsa_pkg::NIL;
    n_wait = 0;
    permit_v = 1'b0;
    permit_m = 0;
    permit_b = 0;
    permit_t = 0;
    pace_v = 1'b0;
    pace_t = 0;
    fail_l = 1'b0;
    fail_c = pfsa_pkg::CS_NONE;
    tot_bytes = 0;
    tot_dgrams = 0;
    rate = pfsa_pkg::RATE_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 0, 0, 0, 0, 0, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 3, 5, 1, 4, 1, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(pfsa_pkg::OP_COMPLETE, 0, 10, 10, 0, 1, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(pfsa_pkg::OP_ABANDON, 0, 0, 0, 0, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_POISON, 0, 0, 0, 0, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(OP_RSVD_LO, 0, 0, 0, 0, 0, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(OP_RSVD_HI, 15, T_MAX, '1, T_MAX, 1, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(6, 9, 77, 5, 88, 0, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 2, 100, 1500, 1000, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 5, 110, 100, 5000, 1, pfsa_pkg::ST_WAIT));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 2, 120, 100, 5000, 1, pfsa_pkg::ST_INVALID));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 7, 130, 100, 9000, 1, pfsa_pkg::ST_WAIT));
    dir_q.push_back(mk(pfsa_pkg::OP_LEAVE, 7, 0, 0, 0, 0, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_LEAVE, 9, 0, 0, 0, 0, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_COMPLETE, 0, 200, 1500, 0, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 5, 300, 100, 5000, 1, pfsa_pkg::ST_MISS));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 5, 300, 100, 20000, 1, pfsa_pkg::ST_WAIT_T));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 5, 12200, 100, 20000, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_ABANDON, 0, 0, 0, 0, 0, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_ACQUIRE, 15, T_MAX, '1, T_MAX, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_COMPLETE, 0, T_MAX, 0, 0, 1, pfsa_pkg::ST_OK));
    dir_q.push_back(mk(pfsa_pkg::OP_LEAVE, 15, 0, 0, 0, 0, pfsa_pkg::ST_OK));
    foreach (dir_q[i]) send_beat(dir_q[i]);

    now = 63'd20000;
    rates[0] = pfsa_pkg::RATE_RST;
    rates[1] = 40'd1;
    rates[2] = RATE_MAX;
    rates[3] = 40'($urandom_range(1000000, 2000000000)) * 40'd7;
    for (int p = 0; p < 4; p++) begin
      write_rate(rates[p]);
      if (p == 1) hold_req <= 1'b1;
      for (int i = 0; i < 280; i++) begin
        if (p == 1 && i == 1) hold_req <= 1'b0;
        send_beat(gen_beat(p == 2));
      end
    end

    // rate zero as the one latched failure, then traffic while failed
    write_rate('0);
    quiet = 1'b1;
    if (permit_v) send_beat(mk(pfsa_pkg::OP_ABANDON, 0, 0, 0, 0, 0, NO_TYPED));
    if (pace_v && pace_t > now) now = pace_t;
    for (int m = 0; m < pfsa_pkg::MEMBERS; m++)
      if (in_q[m]) send_beat(mk(pfsa_pkg::OP_LEAVE, 4'(m), 0, 0, 0, 0, NO_TYPED));
    send_beat(mk(pfsa_pkg::OP_ACQUIRE, 1, now, 100, now + 63'd1000, 1, pfsa_pkg::ST_OK));
    send_beat(mk(pfsa_pkg::OP_COMPLETE, 1, now, 100, 0, 1, pfsa_pkg::ST_OVERFLOW));
    send_beat(mk(pfsa_pkg::OP_ACQUIRE, 1, now, 100, now + 63'd1000, 1, pfsa_pkg::ST_FAILED));
    for (int i = 0; i < 100; i++) begin
      c = gen_beat(1'b0);
      if ($urandom_range(0, 9) == 0) c.op = pfsa_pkg::OP_POISON;
      send_beat(c);
    end

    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d command beats, %0d results, %0d grants, %0d paced completes",
             n_beats, n_results, n_grants, n_paced);
    $display("rates: reset, 1, max, mid, zero; ended with failure cause %0d", fail_c);
    if (errors == 0) $display("paced_fifo_send_arbiter_top regression: pass");
    else $display("paced_fifo_send_arbiter_top regression: fail");
    $finish;
  end

  // receiver backpressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic void chk(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", f, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t e;
    int   ty;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        ty = typed_q.pop_front();
        if (ty != NO_TYPED) chk("status(table)", 64'(ty), 64'(m_axis_tdata[2:0]));
        chk("status", 64'(e.status), 64'(m_axis_tdata[2:0]));
        chk("retry_time_ns", 64'(e.retry), 64'(m_axis_tdata[65:3]));
        chk("wake_valid", 64'(e.wake_v), 64'(m_axis_tdata[66]));
        chk("wake_member", 64'(e.wake_m), 64'(m_axis_tdata[70:67]));
        chk("wake_all", 64'(e.wake_all), 64'(m_axis_tdata[71]));
        chk("waiting_count", 64'(e.waiting), 64'(m_axis_tdata[76:72]));
        chk("charged_bytes", e.chg_bytes, m_axis_tdata[140:77]);
        chk("charged_datagrams", e.chg_dgrams, m_axis_tdata[204:141]);
        chk("failed", 64'(e.failed), 64'(m_axis_tdata[205]));
        chk("failure_cause", 64'(e.cause), 64'(m_axis_tdata[208:206]));
      end
    end
  end

endmodule
